// ===== rtl/core/ism_pkg.sv =====
// ============================================================================
// ism_pkg
// Shared widths, field offsets and codes for the Ising site update engine.
// ============================================================================
package ism_pkg;

  localparam int unsigned MAX_SIDE_DEF = 64;
  localparam int unsigned SIDE_RESET   = 64;

  localparam int unsigned SITE_FW   = 12;
  localparam int unsigned ENERGY_W  = 15;
  localparam int unsigned MAG_W     = 14;
  localparam int unsigned TH_W      = 32;

  // slave tdata: load_site, load_spin_up, random_value
  localparam int unsigned S_TDATA_W   = 48;
  localparam int unsigned S_SPIN_OFF  = SITE_FW;
  localparam int unsigned S_RAND_OFF  = SITE_FW + 1;

  // master tdata: site_touched, flipped, energy_total, magnetization_sum
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned M_PAD_W   = M_TDATA_W - SITE_FW - 1 - ENERGY_W - MAG_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TH4  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TH8  = 2'd2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // lattice read sequence: own site, then the four neighbours
  localparam int unsigned NB_W = 3;
  localparam logic [NB_W-1:0] NB_SELF  = 3'd0;
  localparam logic [NB_W-1:0] NB_RIGHT = 3'd1;
  localparam logic [NB_W-1:0] NB_LEFT  = 3'd2;
  localparam logic [NB_W-1:0] NB_UP    = 3'd3;
  localparam logic [NB_W-1:0] NB_DOWN  = 3'd4;
  localparam logic [NB_W-1:0] NB_DONE  = 3'd5;

endpackage

// ===== rtl/core/ism_nbr_addr.sv =====
// ============================================================================
// ism_nbr_addr
// Periodic neighbour address generation on a square lattice.
// ============================================================================
module ism_nbr_addr #(
  parameter int unsigned MAX_SIDE = ism_pkg::MAX_SIDE_DEF
) (
  input  logic [2*$clog2(MAX_SIDE)-1:0]   site_i,
  input  logic [$clog2(MAX_SIDE)-1:0]     x_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]   side_i,
  input  logic [2*$clog2(MAX_SIDE):0]     n_i,
  input  logic [ism_pkg::NB_W-1:0]        sel_i,
  output logic [2*$clog2(MAX_SIDE)-1:0]   addr_o
);
  import ism_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_SIDE);
  localparam int unsigned ADDR_W = 2 * CW;
  localparam int unsigned N_W    = ADDR_W + 1;

  logic [N_W-1:0] s;
  logic [N_W-1:0] l;
  logic [N_W-1:0] lm1;
  logic [N_W-1:0] right;
  logic [N_W-1:0] left;
  logic [N_W-1:0] up_t;
  logic [N_W-1:0] up;
  logic [N_W-1:0] down;
  logic [N_W-1:0] sel_addr;

  assign s     = N_W'(site_i);
  assign l     = N_W'(side_i);
  assign lm1   = l - N_W'(1);
  assign right = (N_W'(x_i) == lm1) ? s - lm1 : s + N_W'(1);
  assign left  = (x_i == '0) ? s + lm1 : s - N_W'(1);
  assign up_t  = s + l;
  assign up    = (up_t >= n_i) ? up_t - n_i : up_t;
  assign down  = (s >= l) ? s - l : s + n_i - l;

  always_comb begin
    unique case (sel_i)
      NB_RIGHT: sel_addr = right;
      NB_LEFT:  sel_addr = left;
      NB_UP:    sel_addr = up;
      NB_DOWN:  sel_addr = down;
      default:  sel_addr = s;
    endcase
  end

  assign addr_o = sel_addr[ADDR_W-1:0];

endmodule

// ===== rtl/core/ising_metropolis_site_update_top.sv =====
// ============================================================================
// ising_metropolis_site_update_top
// Metropolis single-site update engine for a periodic 2D Ising lattice.
// ============================================================================
// Input items arrive on the s_axis stream; tuser selects load (0) or update (1).
// Every item gives exactly one result item on the m_axis stream, tlast marking
// the last site of a sweep. Energy and magnetization are the running totals
// after the item. Thresholds and side are written on the cfg port while idle.
// Timing: the spin store is a one-bit memory with one read and one write per
// cycle, read through a registered port; an update or an in-range load reads its
// own spin and four neighbours in turn, then updates.
//   update:                reads the five sites, then evaluates
//   load inside lattice:   first finds x (remainder of site by side,
//                          one quotient bit per cycle), then reads as update
//   load outside lattice:  no reads; goes straight to its result
// After reset, and after every side write, all MAX_SIDE*MAX_SIDE spins are set
// to +1 one per cycle; s_axis_tready stays low.
// The result waits in an output register; while it is not taken the engine
// can still accept and work on one more item, and holds that item's result
// until the register frees.
// ============================================================================
module ising_metropolis_site_update_top #(
  parameter int unsigned MAX_SIDE = ism_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // load_site[11:0], load_spin_up[12], random_value[44:13]
  input  logic [ism_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // command
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // site_touched[11:0], flipped[12], energy_total[27:13], magnetization_sum[41:28]
  output logic [ism_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic [ism_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ism_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import ism_pkg::*;

  localparam int unsigned CW        = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int unsigned ADDR_W    = 2 * CW;
  localparam int unsigned N_W       = ADDR_W + 1;
  localparam int unsigned MAX_SITES = MAX_SIDE * MAX_SIDE;
  localparam int unsigned BIT_W     = $clog2(ADDR_W);
  localparam int unsigned LW        = (N_W > SITE_FW) ? N_W : SITE_FW;
  localparam int unsigned RST_SIDE  = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
  localparam int unsigned RST_N     = RST_SIDE * RST_SIDE;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_EVAL  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SIDE_W-1:0]   side_q;
  logic [N_W-1:0]      n_q;
  logic [TH_W-1:0]     th4_q, th8_q;
  logic [ADDR_W-1:0]   clr_q;
  logic [ADDR_W-1:0]   sweep_pos_q;
  logic [CW-1:0]       sweep_x_q;
  logic                m_valid_q;

  logic [ADDR_W-1:0]   site_q;
  logic [SITE_FW-1:0]  raw_site_q;
  logic [CW-1:0]       x_q;
  logic [BIT_W-1:0]    bit_q;
  logic [NB_W-1:0]     cnt_q;
  logic                is_load_q;
  logic                in_range_q;
  logic                new_spin_q;
  logic [TH_W-1:0]     rand_q;
  logic                own_q;
  logic [2:0]          nup_q;
  logic signed [ENERGY_W-1:0] energy_q;
  logic signed [MAG_W-1:0]    mag_q;
  logic [SITE_FW-1:0]  out_site_q;
  logic                out_flip_q;
  logic                out_last_q;

  logic                mem [MAX_SITES];
  logic                rd_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  logic                mem_wd;

  logic                in_cmd;
  logic [SITE_FW-1:0]  in_site;
  logic                in_spin;
  logic [TH_W-1:0]     in_rand;
  logic                in_fire;
  logic                in_range;

  logic [CW:0]         div_t;
  logic                div_ge;
  logic [CW-1:0]       div_r;

  logic [2:0]          k;
  logic                accept;
  logic                do_flip;
  logic signed [4:0]   delta;
  logic                out_ready;
  logic                fire;
  logic                is_last;
  logic                x_wrap;
  logic                clr_done;

  logic [7:0]          side_raw;
  logic [SIDE_W-1:0]   side_new;
  logic [N_W-1:0]      n_new;

  assign in_cmd   = s_axis_tuser;
  assign in_site  = s_axis_tdata[SITE_FW-1:0];
  assign in_spin  = s_axis_tdata[S_SPIN_OFF];
  assign in_rand  = s_axis_tdata[S_RAND_OFF +: TH_W];
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_range = LW'(in_site) < LW'(n_q);

  assign s_axis_tready = (state_q == ST_IDLE);

  // restoring remainder by side, one bit per cycle
  assign div_t  = {x_q, site_q[bit_q]};
  assign div_ge = div_t >= (CW + 1)'(side_q);
  assign div_r  = div_ge ? CW'(div_t - (CW + 1)'(side_q)) : div_t[CW-1:0];

  // aligned neighbours: delta = 4*k - 8
  assign k = own_q ? nup_q : 3'd4 - nup_q;

  always_comb begin
    unique case (k)
      3'd0:    delta = -5'sd8;
      3'd1:    delta = -5'sd4;
      3'd2:    delta = 5'sd0;
      3'd3:    delta = 5'sd4;
      3'd4:    delta = 5'sd8;
      default: delta = 5'sd0;
    endcase
  end

  assign accept = (k <= 3'd2) ||
                  ((k == 3'd3) && (rand_q < th4_q)) ||
                  ((k == 3'd4) && (rand_q < th8_q));
  assign do_flip   = is_load_q ? (in_range_q && (own_q != new_spin_q)) : accept;
  assign out_ready = !m_valid_q || m_axis_tready;
  assign fire      = (state_q == ST_EVAL) && out_ready;
  assign is_last   = N_W'(site_q) == (n_q - N_W'(1));
  assign x_wrap    = (CW + 1)'(x_q) == ((CW + 1)'(side_q) - (CW + 1)'(1));
  assign clr_done  = clr_q == ADDR_W'(MAX_SITES - 1);

  assign side_raw = {1'b0, cfg_wdata_i[6:0]};
  always_comb begin
    priority if (side_raw < 8'd2) begin
      side_new = SIDE_W'(2);
    end else if (32'(side_raw) > MAX_SIDE) begin
      side_new = SIDE_W'(MAX_SIDE);
    end else begin
      side_new = SIDE_W'(side_raw);
    end
  end
  assign n_new = N_W'(side_new) * N_W'(side_new);

  ism_nbr_addr #(
    .MAX_SIDE (MAX_SIDE)
  ) u_nbr_addr (
    .site_i (site_q),
    .x_i    (x_q),
    .side_i (side_q),
    .n_i    (n_q),
    .sel_i  (cnt_q),
    .addr_o (rd_addr)
  );

  assign mem_we = (state_q == ST_CLEAR) || (fire && do_flip);
  assign mem_wa = (state_q == ST_CLEAR) ? clr_q : site_q;
  assign mem_wd = (state_q == ST_CLEAR) ? 1'b1 : !own_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_LOAD) begin
            state_d = in_range ? ST_DIV : ST_EVAL;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_DIV:  if (bit_q == '0) state_d = ST_READ;
      ST_READ: if (cnt_q == NB_DONE) state_d = ST_EVAL;
      ST_EVAL: if (out_ready) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
    if (cfg_we_i && (cfg_idx_i == CFG_SIDE)) begin
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      side_q      <= SIDE_W'(RST_SIDE);
      n_q         <= N_W'(RST_N);
      th4_q       <= '0;
      th8_q       <= '0;
      clr_q       <= '0;
      sweep_pos_q <= '0;
      sweep_x_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        sweep_pos_q <= '0;
        sweep_x_q   <= '0;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_SIDE)) begin
        clr_q <= '0;
      end else if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (fire) begin
        m_valid_q <= 1'b1;
        if (!is_load_q) begin
          sweep_pos_q <= is_last ? '0 : site_q + ADDR_W'(1);
          sweep_x_q   <= x_wrap ? '0 : x_q + CW'(1);
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SIDE: begin
            side_q <= side_new;
            n_q    <= n_new;
          end
          CFG_TH4: th4_q <= cfg_wdata_i[TH_W-1:0];
          CFG_TH8: th8_q <= cfg_wdata_i[TH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_CLEAR: begin
        energy_q <= ENERGY_W'(0) - ENERGY_W'({n_q, 1'b0});
        mag_q    <= MAG_W'(n_q);
      end
      ST_IDLE: begin
        if (in_fire) begin
          is_load_q  <= (in_cmd == CMD_LOAD);
          raw_site_q <= in_site;
          new_spin_q <= in_spin;
          rand_q     <= in_rand;
          in_range_q <= in_range;
          nup_q      <= '0;
          cnt_q      <= NB_SELF;
          bit_q      <= BIT_W'(ADDR_W - 1);
          if (in_cmd == CMD_LOAD) begin
            site_q <= ADDR_W'(in_site);
            x_q    <= '0;
          end else begin
            site_q <= sweep_pos_q;
            x_q    <= sweep_x_q;
          end
        end
      end
      ST_DIV: begin
        x_q   <= div_r;
        bit_q <= bit_q - BIT_W'(1);
      end
      ST_READ: begin
        cnt_q <= cnt_q + NB_W'(1);
        // read data comes from a registered port, so each step takes the data addressed in the step before
        if (cnt_q == NB_RIGHT) begin
          own_q <= rd_q;
        end else if (cnt_q != NB_SELF) begin
          nup_q <= nup_q + {2'b00, rd_q};
        end
      end
      ST_EVAL: begin
        if (fire) begin
          out_site_q <= is_load_q ? raw_site_q : SITE_FW'(site_q);
          out_flip_q <= !is_load_q && accept;
          out_last_q <= !is_load_q && is_last;
          if (do_flip) begin
            energy_q <= energy_q + ENERGY_W'(delta);
            mag_q    <= own_q ? mag_q - MAG_W'(2) : mag_q + MAG_W'(2);
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, mag_q, energy_q, out_flip_q, out_site_q};

endmodule
